/* hdl/iirdf1_pkg.sv */
// Shared types and constants for the direct form I IIR filter.
// No dependencies; imported by iirdf1_datapath and iir_direct_form_one_filter.
package iirdf1_pkg;

  localparam int MaxTaps       = 4;
  localparam int HistDepth     = MaxTaps - 1;
  localparam int CoefFracBits  = 20;
  localparam int StateFracBits = 12;

  localparam int SmpW     = 16;
  localparam int CoefW    = 24;
  localparam int YW       = 32;
  localparam int TapsW    = 3;
  localparam int CfgIdxW  = 3;
  localparam int FfProdW  = CoefW + SmpW;
  localparam int FbProdW  = CoefW + YW;
  localparam int AccW     = 60;

  localparam logic signed [SmpW-1:0] SampleMax = 16'sh7FFF;
  localparam logic signed [SmpW-1:0] SampleMin = 16'sh8000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TAPS = 3'd0,
    REG_FF0  = 3'd1,
    REG_FF1  = 3'd2,
    REG_FF2  = 3'd3,
    REG_FF3  = 3'd4,
    REG_FB1  = 3'd5,
    REG_FB2  = 3'd6,
    REG_FB3  = 3'd7
  } reg_idx_e;

  typedef logic signed [SmpW-1:0] smp_t;
  typedef logic signed [YW-1:0]   ystate_t;

  typedef struct packed {
    logic [TapsW-1:0]                 taps;
    logic [MaxTaps-1:0][CoefW-1:0]    ff;
    logic [MaxTaps-1:1][CoefW-1:0]    fb;
  } cfg_t;

  typedef struct packed {
    ystate_t y_new;
    smp_t    sample;
    logic    clip;
  } res_t;

endpackage

/* hdl/iirdf1_datapath.sv */
// Multiply-accumulate, rounding and saturation for one sample.
// Depends on iirdf1_pkg.
module iirdf1_datapath (
  input  iirdf1_pkg::cfg_t    cfg_i,
  input  iirdf1_pkg::smp_t    x_i,
  input  logic                first_i,
  input  iirdf1_pkg::smp_t    x_hist_i [iirdf1_pkg::HistDepth],
  input  iirdf1_pkg::ystate_t y_hist_i [iirdf1_pkg::HistDepth],
  output iirdf1_pkg::res_t    res_o
);
  import iirdf1_pkg::*;

  localparam logic [AccW-1:0] CoefRound  = (AccW'(1) << CoefFracBits) - AccW'(1);
  localparam logic [YW-1:0]   StateRound = (YW'(1) << StateFracBits) - YW'(1);

  logic [TapsW-1:0]           taps_eff;
  logic signed [SmpW-1:0]     xv      [MaxTaps];
  logic signed [YW-1:0]       yv      [HistDepth];
  logic signed [FfProdW-1:0]  ff_prod [MaxTaps];
  logic signed [FbProdW-1:0]  fb_prod [HistDepth];
  logic signed [AccW-1:0]     acc;
  logic signed [AccW-1:0]     acc_adj;
  logic signed [AccW-1:0]     q;
  logic signed [YW-1:0]       y_new;
  logic signed [YW-1:0]       y_adj;
  logic signed [YW-1:0]       y_q;

  always_comb begin
    taps_eff = (cfg_i.taps > TapsW'(MaxTaps)) ? TapsW'(MaxTaps) : cfg_i.taps;

    // first sample sees zeroed history
    xv[0] = x_i;
    for (int i = 1; i < MaxTaps; i++) begin
      xv[i] = first_i ? '0 : x_hist_i[i-1];
    end
    for (int i = 0; i < HistDepth; i++) begin
      yv[i] = first_i ? '0 : y_hist_i[i];
    end

    for (int i = 0; i < MaxTaps; i++) begin
      ff_prod[i] = $signed(cfg_i.ff[i]) * xv[i];
    end
    for (int i = 0; i < HistDepth; i++) begin
      fb_prod[i] = $signed(cfg_i.fb[i+1]) * yv[i];
    end

    acc = '0;
    for (int i = 0; i < MaxTaps; i++) begin
      if (TapsW'(i) < taps_eff) begin
        acc = acc + (AccW'(ff_prod[i]) <<< StateFracBits);
      end
    end
    for (int i = 0; i < HistDepth; i++) begin
      if (TapsW'(i + 1) < taps_eff) begin
        acc = acc - AccW'(fb_prod[i]);
      end
    end

    // truncate toward zero, then clamp to 32-bit state
    acc_adj = acc + (acc[AccW-1] ? $signed(CoefRound) : '0);
    q       = acc_adj >>> CoefFracBits;
    if (&q[AccW-1:YW-1] || ~|q[AccW-1:YW-1]) begin
      y_new = q[YW-1:0];
    end else begin
      y_new = q[AccW-1] ? {1'b1, {(YW-1){1'b0}}} : {1'b0, {(YW-1){1'b1}}};
    end

    y_adj = y_new + (y_new[YW-1] ? $signed(StateRound) : '0);
    y_q   = y_adj >>> StateFracBits;

    res_o.y_new = y_new;
    if (&y_q[YW-1:SmpW-1] || ~|y_q[YW-1:SmpW-1]) begin
      res_o.sample = y_q[SmpW-1:0];
      res_o.clip   = 1'b0;
    end else begin
      res_o.sample = y_q[YW-1] ? SampleMin : SampleMax;
      res_o.clip   = 1'b1;
    end
  end

endmodule

/* hdl/iir_direct_form_one_filter.sv */
// Direct form I IIR filter, up to four feed-forward and three feedback taps.
// An accepted request moves through the input register, then the result register, to the output.
// Throughput: one sample per cycle unless the output stalls; the whole MAC tree and the
// history update sit between the input register and the result register.
// Reset: coefficients to b0 = 1.0, others 0, four taps; histories cleared.
// Depends on iirdf1_pkg and iirdf1_datapath.
module iir_direct_form_one_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [iirdf1_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [iirdf1_pkg::CoefW-1:0]  cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] sample_in
  input  logic                          s_axis_tuser,   // [0] first_sample
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [15:0] sample_out
  output logic                          m_axis_tuser    // [0] clipped
);
  import iirdf1_pkg::*;

  // four taps, b0 = 1.0, everything else zero
  localparam cfg_t CfgReset = '{
    taps: TapsW'(MaxTaps),
    ff:   (MaxTaps*CoefW)'(1 << CoefFracBits),
    fb:   '0
  };

  cfg_t    cfg_q;
  smp_t    x_hist_q [HistDepth];
  ystate_t y_hist_q [HistDepth];

  logic    s1_valid_q;
  smp_t    s1_x_q;
  logic    s1_first_q;

  logic    out_valid_q;
  smp_t    out_sample_q;
  logic    out_clip_q;

  logic    advance;
  res_t    res;

  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;

  iirdf1_datapath u_datapath (
    .cfg_i    (cfg_q),
    .x_i      (s1_x_q),
    .first_i  (s1_first_q),
    .x_hist_i (x_hist_q),
    .y_hist_i (y_hist_q),
    .res_o    (res)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TAPS: cfg_q.taps  <= cfg_data_i[TapsW-1:0];
        REG_FF0:  cfg_q.ff[0] <= cfg_data_i;
        REG_FF1:  cfg_q.ff[1] <= cfg_data_i;
        REG_FF2:  cfg_q.ff[2] <= cfg_data_i;
        REG_FF3:  cfg_q.ff[3] <= cfg_data_i;
        REG_FB1:  cfg_q.fb[1] <= cfg_data_i;
        REG_FB2:  cfg_q.fb[2] <= cfg_data_i;
        REG_FB3:  cfg_q.fb[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_x_q     <= s_axis_tdata;
      s1_first_q <= s_axis_tuser;
    end
  end

  // history shifts once per sample moving into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistDepth; i++) begin
        x_hist_q[i] <= '0;
        y_hist_q[i] <= '0;
      end
    end else if (advance) begin
      x_hist_q[0] <= s1_x_q;
      y_hist_q[0] <= res.y_new;
      for (int i = 1; i < HistDepth; i++) begin
        x_hist_q[i] <= s1_first_q ? '0 : x_hist_q[i-1];
        y_hist_q[i] <= s1_first_q ? '0 : y_hist_q[i-1];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sample_q <= res.sample;
      out_clip_q   <= res.clip;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = out_clip_q;

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("sample moved on but result register is empty");

  a_no_drop_in_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q)
    else $error("stalled input register lost its request");

  a_hist_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(x_hist_q[0]) && $stable(y_hist_q[0]))
    else $error("history changed without a sample");

  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_first_q |=> x_hist_q[1] == '0 && y_hist_q[1] == '0)
    else $error("first sample did not clear history");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_clip_q |-> out_sample_q == SampleMax || out_sample_q == SampleMin)
    else $error("clipped flag set on an unsaturated sample");

endmodule

/* verif/iir_direct_form_one_filter_test.sv */
// Self-checking testbench for iir_direct_form_one_filter: directed corner cases, then random
// coefficient sets and samples, checked against an in-bench fixed-point filter predictor.
// Depends on iirdf1_pkg and the filter RTL.
`timescale 1ns / 100ps

module iir_direct_form_one_filter_test;
  import iirdf1_pkg::*;

  localparam int WatchdogLimit  = 2000;
  localparam int SinkHoldCycles = 60;
  localparam int IdlePct        = 28;
  localparam int DrainCycles    = 8;
  localparam int MaxReports     = 10;
  localparam int RandomItems    = 430;

  typedef struct packed {
    smp_t sample;
    logic first;
  } smp_req_t;

  typedef struct packed {
    smp_t sample;
    logic clip;
  } filt_out_t;

  typedef logic [CoefW-1:0] coef_set_t [MaxTaps];

  typedef enum int {
    COEF_STABLE,
    COEF_WILD,
    COEF_CORNER
  } coef_mode_e;

  localparam logic [CoefW-1:0] CoefCorners [5] = '{
    24'h7FFFFF, 24'h800000, 24'h000000, 24'h100000, 24'hFFFFFF
  };
  localparam logic [SmpW-1:0] SmpCorners [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CoefW-1:0]    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;
  logic                m_axis_tuser;

  iir_direct_form_one_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the filter configuration and history
  logic [TapsW-1:0]        cfg_taps;
  logic signed [CoefW-1:0] ff_coef [MaxTaps];
  logic signed [CoefW-1:0] fb_coef [MaxTaps];  // entry 0 unused
  smp_t                    x_hist  [HistDepth];
  ystate_t                 y_hist  [HistDepth];

  smp_req_t  sample_req_q [$];
  filt_out_t expected_out_q [$];
  smp_req_t  cur_req;
  filt_out_t want;

  int src_idle_pct  = IdlePct;
  int sink_idle_pct = IdlePct;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int n_errors      = 0;
  int n_accepted    = 0;
  int n_results     = 0;
  int n_clipped     = 0;
  int n_clears      = 0;
  int n_settings    = 0;

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= MaxReports) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // One filter step: y = sum b*x - sum a*y, y history kept with StateFracBits fraction bits.
  function automatic filt_out_t filter_sample(input smp_t x, input logic first);
    longint    acc;
    longint    xv;
    longint    y_full;
    longint    y_out;
    int        n_taps;
    int        i;
    filt_out_t r;
    if (first) begin
      x_hist = '{default: '0};
      y_hist = '{default: '0};
    end
    n_taps = (cfg_taps > MaxTaps) ? MaxTaps : int'(cfg_taps);
    acc = 0;
    for (i = 0; i < n_taps; i++) begin
      if (i == 0) xv = longint'(x);
      else xv = longint'(x_hist[i-1]);
      acc += longint'(ff_coef[i]) * xv * (longint'(1) << StateFracBits);
    end
    for (i = 1; i < n_taps; i++) acc -= longint'(fb_coef[i]) * longint'(y_hist[i-1]);
    y_full = acc / (longint'(1) << CoefFracBits);
    if (y_full > 64'sd2147483647) y_full = 64'sd2147483647;
    else if (y_full < -64'sd2147483648) y_full = -64'sd2147483648;
    y_out = y_full / (longint'(1) << StateFracBits);
    r.clip = 1'b0;
    if (y_out > longint'(SampleMax)) begin
      y_out  = longint'(SampleMax);
      r.clip = 1'b1;
    end else if (y_out < longint'(SampleMin)) begin
      y_out  = longint'(SampleMin);
      r.clip = 1'b1;
    end
    r.sample = y_out[SmpW-1:0];
    for (i = HistDepth - 1; i > 0; i--) begin
      x_hist[i] = x_hist[i-1];
      y_hist[i] = y_hist[i-1];
    end
    x_hist[0] = x;
    y_hist[0] = y_full[YW-1:0];
    return r;
  endfunction

  // input side: offers queued requests, holds each until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_out_q.push_back(filter_sample(cur_req.sample, cur_req.first));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_req_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_req = sample_req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_req.sample;
          s_axis_tuser  <= cur_req.first;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: random backpressure plus an occasional long hold
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (m_axis_tuser) n_clipped++;
        if (expected_out_q.size() == 0) begin
          flag_error($sformatf("result %0d with nothing expected: sample_out=%0d",
                               n_results, $signed(m_axis_tdata)));
        end else begin
          want = expected_out_q.pop_front();
          if (m_axis_tdata !== want.sample)
            flag_error($sformatf("result %0d sample_out: expected %0d, got %0d",
                                 n_results, want.sample, $signed(m_axis_tdata)));
          if (m_axis_tuser !== want.clip)
            flag_error($sformatf("result %0d clipped: expected %0b, got %0b",
                                 n_results, want.clip, m_axis_tuser));
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = SinkHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no request accepted for %0d cycles", WatchdogLimit);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [CoefW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == REG_TAPS) cfg_taps = val[TapsW-1:0];
    else if (idx <= REG_FF3) ff_coef[idx - REG_FF0] = val;
    else fb_coef[idx - REG_FB1 + 1] = val;
  endtask

  task automatic apply_settings(input logic [TapsW-1:0] taps, input coef_set_t ff,
                                input coef_set_t fb);
    write_reg(REG_TAPS, CoefW'(taps));
    write_reg(REG_FF0, ff[0]);
    write_reg(REG_FF1, ff[1]);
    write_reg(REG_FF2, ff[2]);
    write_reg(REG_FF3, ff[3]);
    write_reg(REG_FB1, fb[1]);
    write_reg(REG_FB2, fb[2]);
    write_reg(REG_FB3, fb[3]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
    @(negedge clk_i);
  endtask

  task automatic push_req(input logic [SmpW-1:0] sample, input logic first);
    smp_req_t req;
    req.sample = sample;
    req.first  = first;
    if (first) n_clears++;
    sample_req_q.push_back(req);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_req_q.size() != 0 || s_axis_tvalid || expected_out_q.size() != 0);
  endtask

  function automatic logic [CoefW-1:0] rand_coef(input coef_mode_e mode, input int span);
    int v;
    case (mode)
      COEF_STABLE: begin
        v = int'($urandom_range((1 << span) - 1)) - (1 << (span - 1));
        return v[CoefW-1:0];
      end
      COEF_WILD: return CoefW'($urandom);
      default: return CoefCorners[$urandom_range(4)];
    endcase
  endfunction

  function automatic logic [SmpW-1:0] rand_sample();
    if ($urandom_range(9) == 0) return SmpCorners[$urandom_range(3)];
    return SmpW'($urandom);
  endfunction

  coef_set_t        ff_set;
  coef_set_t        fb_set;
  coef_mode_e       mode;
  logic [TapsW-1:0] taps;
  int               n_batch;
  int               n_random;
  int               phase;

  initial begin
    cfg_taps = TapsW'(MaxTaps);
    ff_coef  = '{default: '0};
    fb_coef  = '{default: '0};
    ff_coef[0] = CoefW'(1 << CoefFracBits);
    x_hist   = '{default: '0};
    y_hist   = '{default: '0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset coefficients give a pass-through filter
    push_req(16'h7FFF, 1'b1);
    push_req(16'h8000, 1'b0);
    push_req(16'h0000, 1'b0);
    push_req(16'h0001, 1'b0);
    push_req(16'hFFFF, 1'b0);
    push_req(16'h5A5A, 1'b0);
    wait_drained();

    // zero taps: every output is zero
    apply_settings(3'd0, '{default: 24'h7FFFFF}, '{default: 24'h800000});
    push_req(16'h7FFF, 1'b0);
    push_req(16'h8000, 1'b0);
    wait_drained();

    // taps above the maximum act as four; extreme gains saturate
    apply_settings(3'd7, '{default: 24'h7FFFFF}, '{default: 24'h800000});
    push_req(16'h7FFF, 1'b1);
    push_req(16'h7FFF, 1'b0);
    push_req(16'h8000, 1'b0);
    push_req(16'h8000, 1'b0);
    push_req(16'h0000, 1'b0);
    push_req(16'h0000, 1'b0);
    wait_drained();

    // runaway feedback drives the y history into 32-bit saturation; mid-stream clear
    apply_settings(3'd5, '{24'h800000, 24'h0, 24'h0, 24'h0},
                   '{24'h0, 24'h7FFFFF, 24'h0, 24'h0});
    push_req(16'h8000, 1'b1);
    push_req(16'h0001, 1'b0);
    push_req(16'h0000, 1'b0);
    push_req(16'h0064, 1'b1);
    push_req(16'h0000, 1'b0);
    wait_drained();

    apply_settings(3'd2, '{24'h080000, 24'h080000, 24'h0, 24'h0},
                   '{24'h0, 24'hF80000, 24'h0, 24'h0});
    push_req(16'h1000, 1'b1);
    push_req(16'hF000, 1'b0);
    push_req(16'h7FFF, 1'b0);
    wait_drained();

    n_random = 0;
    phase    = 0;
    while (n_random < RandomItems) begin
      phase++;
      case ($urandom_range(99) / 20)
        0, 1, 2: mode = COEF_STABLE;
        3:       mode = COEF_WILD;
        default: mode = COEF_CORNER;
      endcase
      if ($urandom_range(3) == 0) taps = TapsW'($urandom_range(7));
      else taps = TapsW'($urandom_range(4, 1));
      for (int k = 0; k < MaxTaps; k++) begin
        ff_set[k] = rand_coef(mode, 20);
        fb_set[k] = rand_coef(mode, 19);
      end
      apply_settings(taps, ff_set, fb_set);

      n_batch = $urandom_range(60, 20);
      for (int k = 0; k < n_batch; k++)
        push_req(rand_sample(), (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(31) == 0));
      n_random += n_batch;

      if (phase == 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (phase == 6) begin
        // output held off while input keeps offering, so the pipeline backs up
        src_idle_pct  = 0;
        sink_idle_pct = IdlePct;
        hold_reqs++;
      end else begin
        src_idle_pct  = IdlePct;
        sink_idle_pct = IdlePct;
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Filtered %0d samples (%0d results, %0d clipped) under %0d coefficient settings,",
             n_accepted, n_results, n_clipped, n_settings);
    $display("with %0d history clears, taps 0..7, corner gains and a %0d-cycle output hold.",
             n_clears, SinkHoldCycles);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/iirdf1_pkg.sv
hdl/iirdf1_datapath.sv
hdl/iir_direct_form_one_filter.sv
verif/iir_direct_form_one_filter_test.sv
